/* rtl/msls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msls_pkg
// Shared types and constants of the scaled minimal standard noise source.
// ----------------------------------------------------------------------------
package msls_pkg;

    localparam int FRAC_BITS = 16;

    localparam int STATE_W  = 31;
    localparam int VALUE_W  = 32;
    localparam int DIFF_W   = VALUE_W + 1;
    localparam int MULT_W   = 15;
    localparam int PROD_W   = STATE_W + MULT_W;
    localparam int HALF_W   = 16;
    localparam int ACC_W    = 64;
    localparam int ADDR_W   = 4;
    localparam int IDX_W    = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 64;

    localparam logic [MULT_W-1:0]  LCG_MULT = MULT_W'(16807);
    localparam logic [STATE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

    localparam logic [STATE_W-1:0] SEED_RST       = STATE_W'(1);
    localparam logic [VALUE_W-1:0] RANGE_STOP_RST = VALUE_W'(64'd1 << FRAC_BITS);

    localparam logic [IDX_W-1:0] REG_SEED  = 2'd0;
    localparam logic [IDX_W-1:0] REG_START = 2'd1;
    localparam logic [IDX_W-1:0] REG_STOP  = 2'd2;

    typedef struct packed {
        logic               load;
        logic [STATE_W-1:0] value;
    } seed_load_t;

    typedef struct packed {
        logic start;
        logic fold;
        logic reduce;
        logic scale_lo;
        logic scale_hi;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/minimal_standard_lcg_scaled_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_standard_lcg_scaled_core
// Park-Miller minimal standard noise source with a scaled Q16.16 output.
//
//   channel   dir   width  fields (low bit first)
//   s_axis    in    8      draw[0]
//   m_axis    out   64     sample[31:0], raw_state[62:32]
//   apb       in    4/32   seed 0x0, range_start 0x4, range_stop 0x8
//
// a draw transfer runs the generator step (multiply on acceptance, fold,
// reduce) and then the two passes of the shared 33x17 scaling multiplier; a
// report-only transfer goes straight to the two scaling passes; the result
// is loaded into the output register once that register is free, and the
// input is ready again in the cycle after that hand-off
// one transfer is in flight at a time; a new one is taken while the last
// result waits in the output register
// synchronous active-low reset; generator state resets to 1
// ----------------------------------------------------------------------------
module minimal_standard_lcg_scaled_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msls_pkg::S_DATA_W-1:0]   s_tdata,   // draw[0], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msls_pkg::M_DATA_W-1:0]   m_tdata,   // sample, raw_state, pad
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msls_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import msls_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    seed_load_t         seed_load;
    logic [VALUE_W-1:0] range_start;
    logic [VALUE_W-1:0] range_stop;

    msls_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .range_start (range_start),
        .range_stop  (range_stop),
        .seed_load   (seed_load)
    );

    msls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .draw     (s_tdata[0]),
        .status   (status),
        .cmd      (cmd)
    );

    msls_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .seed_load   (seed_load),
        .range_start (range_start),
        .range_stop  (range_stop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* rtl/msls_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msls_regs
// APB register file: seed, range start and range stop.
// ----------------------------------------------------------------------------
module msls_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msls_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [msls_pkg::VALUE_W-1:0]   range_start,
    output logic [msls_pkg::VALUE_W-1:0]   range_stop,
    output msls_pkg::seed_load_t           seed_load
);
    import msls_pkg::*;

    logic [STATE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] start_reg;
    logic [VALUE_W-1:0] stop_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] seed_wr;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign idx     = paddr[ADDR_W-1:2];
    assign seed_wr = pwdata[STATE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= SEED_RST;
            start_reg <= '0;
            stop_reg  <= RANGE_STOP_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_SEED:  seed_reg  <= seed_wr;
                REG_START: start_reg <= pwdata;
                REG_STOP:  stop_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // zero and all-ones would lock the generator
    always_comb begin
        seed_load.load  = wr_en && (idx == REG_SEED);
        seed_load.value = seed_wr;
        if (seed_wr == '0 || seed_wr == LCG_MOD) begin
            seed_load.value = SEED_RST;
        end
    end

    always_comb begin
        unique case (idx)
            REG_SEED:  prdata = {1'b0, seed_reg};
            REG_START: prdata = start_reg;
            REG_STOP:  prdata = stop_reg;
            default:   prdata = '0;
        endcase
    end

    assign range_start = start_reg;
    assign range_stop  = stop_reg;

endmodule

/* rtl/msls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msls_ctrl
// Sequencer: generator step, two-pass scaling multiply, result hand-off.
// ----------------------------------------------------------------------------
module msls_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    draw,
    input  msls_pkg::dp_status_t    status,
    output msls_pkg::dp_cmd_t       cmd
);
    import msls_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FOLD   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_SLO    = 6'b001000,
        ST_SHI    = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = draw ? ST_FOLD : ST_SLO;
                end
            end
            ST_FOLD:   state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_SLO;
            ST_SLO:    state_next = ST_SHI;
            ST_SHI:    state_next = ST_FIN;
            ST_FIN: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd.start    = accept;
        cmd.fold     = (state_reg == ST_FOLD);
        cmd.reduce   = (state_reg == ST_REDUCE);
        cmd.scale_lo = (state_reg == ST_SLO);
        cmd.scale_hi = (state_reg == ST_SHI);
        cmd.finish   = (state_reg == ST_FIN) && status.out_free;
    end

endmodule

/* rtl/msls_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msls_dpath
// Generator state, Mersenne fold, shared 33x17 scaling multiplier, output reg.
// ----------------------------------------------------------------------------
module msls_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  msls_pkg::dp_cmd_t               cmd,
    output msls_pkg::dp_status_t            status,
    input  msls_pkg::seed_load_t            seed_load,
    input  logic [msls_pkg::VALUE_W-1:0]    range_start,
    input  logic [msls_pkg::VALUE_W-1:0]    range_stop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msls_pkg::M_DATA_W-1:0]   m_tdata
);
    import msls_pkg::*;

    logic [STATE_W-1:0]       state_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [STATE_W:0]         fold_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [VALUE_W-1:0]       sample_reg;
    logic [STATE_W-1:0]       raw_reg;
    logic                     valid_reg;

    logic signed [HALF_W:0]          mul_b;
    logic signed [DIFF_W+HALF_W:0]   mul_p;
    logic [STATE_W:0]                fold_sub;

    assign status.out_free = !valid_reg || m_tready;

    // upper half taken in the second pass
    assign mul_b = cmd.scale_hi ? (HALF_W+1)'(state_reg[STATE_W-1:HALF_W])
                                : (HALF_W+1)'(state_reg[HALF_W-1:0]);
    assign mul_p = diff_reg * mul_b;

    always_comb begin
        if (cmd.scale_hi) begin
            acc_next = acc_reg + (ACC_W'(mul_p) <<< HALF_W);
        end else begin
            acc_next = ACC_W'(mul_p);
        end
    end

    assign fold_sub = fold_reg - {1'b0, LCG_MOD};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RST;
        end else if (seed_load.load) begin
            state_reg <= seed_load.value;
        end else if (cmd.reduce) begin
            state_reg <= (fold_reg >= {1'b0, LCG_MOD}) ? fold_sub[STATE_W-1:0]
                                                       : fold_reg[STATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            prod_reg <= PROD_W'(state_reg) * PROD_W'(LCG_MULT);
            diff_reg <= $signed({range_stop[VALUE_W-1], range_stop})
                      - $signed({range_start[VALUE_W-1], range_start});
        end
        if (cmd.fold) begin
            fold_reg <= {1'b0, prod_reg[STATE_W-1:0]}
                      + (STATE_W+1)'(prod_reg[PROD_W-1:STATE_W]);
        end
        if (cmd.scale_lo || cmd.scale_hi) begin
            acc_reg <= acc_next;
        end
        // floor of the product over 2^31 is an arithmetic shift
        if (cmd.finish) begin
            sample_reg <= range_start + acc_reg[STATE_W+VALUE_W-1:STATE_W];
            raw_reg    <= state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, raw_reg, sample_reg};

endmodule
